// ===== src/gcd_pkg.sv =====
package gcd_pkg;

  localparam int unsigned DenomW       = 31;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned DenomSlotsDef = 7;
  localparam int unsigned CntW         = 5;

  // configuration register indexes
  localparam logic [SlotW-1:0] RegActiveCount = 3'd0;
  localparam logic [SlotW-1:0] RegDenomBase   = 3'd1;

  typedef struct packed {
    logic              vld;
    logic [DenomW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== src/gcd_sort_cell.sv =====
module gcd_sort_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gcd_pkg::cell_ctrl_t         ctrl_i,
  input  logic [gcd_pkg::DenomW-1:0]  new_value_i,
  input  gcd_pkg::entry_t             prev_i,
  input  gcd_pkg::entry_t             next_i,
  output gcd_pkg::entry_t             entry_o
);

  gcd_pkg::entry_t entry_q, entry_d;
  logic gt_prev, gt_self;

  // an empty slot ranks below any value; equal values keep their place
  assign gt_prev = !prev_i.vld || (new_value_i > prev_i.value);
  assign gt_self = !entry_q.vld || (new_value_i > entry_q.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clr) begin
      entry_d.vld = 1'b0;
    end else if (ctrl_i.ins) begin
      if (gt_prev) begin
        entry_d = prev_i;
      end else if (gt_self) begin
        entry_d.vld   = 1'b1;
        entry_d.value = new_value_i;
      end
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.vld   <= 1'b0;
      entry_q.value <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== src/gcd_divider.sv =====
module gcd_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gcd_pkg::DenomW-1:0]  dividend_i,
  input  logic [gcd_pkg::DenomW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [gcd_pkg::DenomW-1:0]  quotient_o,
  output logic [gcd_pkg::DenomW-1:0]  remainder_o
);

  localparam int unsigned W = gcd_pkg::DenomW;

  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q;
  logic [gcd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;
  logic       fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      rem_d = fits ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == gcd_pkg::CntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dsr_q <= divisor_i;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== src/greedy_change_dispenser_core.sv =====
// Greedy change dispenser.
// Slave stream: one word per withdrawal request, tdata holds the amount.
// Master stream: one word per active denomination, largest value first
// (equal values in slot order), carrying the denomination, the number of
// pieces and the amount still unpaid; tlast marks the final word, whose
// remainder is what could not be paid. With no active slots one word with
// denomination 0 and count 0 is given.
// Config channel: index 0 writes active_count, indexes 1..7 write the
// denomination slots; writes are taken in every cycle.
// Sequence: a request loads n active slots into a row of sort cells, one slot
// per cycle, then takes a decision step, then runs one bit-serial division
// per denomination: a start step, the quotient bits, a done step and an
// output step.
// One request is in work at a time; tready is high only between requests.
// Receiver stall: the pending word holds in the output register and the
// block waits; nothing is dropped.
// Reset: active_count clears to 0, all denominations to 1, the block idles.
module greedy_change_dispenser_core #(
  parameter int unsigned DENOM_SLOTS = gcd_pkg::DenomSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] amount
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [30:0] denomination, [61:31] piece_count,
                                      // [92:62] remaining
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  localparam int unsigned W  = gcd_pkg::DenomW;
  localparam int unsigned SW = gcd_pkg::SlotW;

  typedef enum logic [2:0] {
    StIdle, StLoad, StStart, StDiv, StOut
  } state_e;

  state_e state_q;

  // configuration registers
  logic [SW-1:0] active_q;
  logic [W-1:0]  denom_q [DENOM_SLOTS];
  logic [SW-1:0] n_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < DENOM_SLOTS; i++) denom_q[i] <= W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gcd_pkg::RegActiveCount) begin
        active_q <= cfg_data_i[SW-1:0];
      end else begin
        for (int i = 0; i < DENOM_SLOTS; i++) begin
          if (cfg_index_i == SW'(gcd_pkg::RegDenomBase + SW'(i))) denom_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  // clamp the slot count to the built row
  assign n_act = (active_q > SW'(DENOM_SLOTS)) ? SW'(DENOM_SLOTS) : active_q;

  // sort row
  gcd_pkg::cell_ctrl_t cell_ctrl;
  gcd_pkg::entry_t     cells [DENOM_SLOTS];
  gcd_pkg::entry_t     top_entry, bottom_entry;
  logic [SW-1:0]       ptr_q;
  logic [W-1:0]        ins_value;

  assign top_entry.vld      = 1'b1;
  assign top_entry.value    = '1;
  assign bottom_entry.vld   = 1'b0;
  assign bottom_entry.value = '0;
  assign ins_value = denom_q[ptr_q];

  for (genvar g = 0; g < DENOM_SLOTS; g++) begin : g_cell
    gcd_sort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .new_value_i (ins_value),
      .prev_i      ((g == 0) ? top_entry : cells[(g == 0) ? 0 : g - 1]),
      .next_i      ((g == DENOM_SLOTS - 1) ? bottom_entry
                                           : cells[(g == DENOM_SLOTS - 1) ? g : g + 1]),
      .entry_o     (cells[g])
    );
  end

  // shared divider
  logic         div_start, div_done;
  logic [W-1:0] div_quo, div_rem;
  logic [W-1:0] left_q;

  gcd_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (left_q),
    .divisor_i   (cells[0].value),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  logic [W-1:0] out_denom_q, out_count_q;
  logic         out_last_q, out_vld_q;

  assign div_start = (state_q == StStart);

  always_comb begin
    cell_ctrl.clr   = (state_q == StIdle) && s_axis_tvalid;
    cell_ctrl.ins   = (state_q == StLoad) && (ptr_q != n_act);
    cell_ctrl.shift = (state_q == StOut) && m_axis_tready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      out_vld_q   <= 1'b0;
      left_q      <= '0;
      out_denom_q <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            left_q <= s_axis_tdata[W-1:0];
            ptr_q  <= '0;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          if (ptr_q != n_act) begin
            ptr_q <= ptr_q + 1'b1;
          end else if (n_act == '0) begin
            // no active slots: one flagged empty word
            out_denom_q <= '0;
            out_count_q <= '0;
            out_last_q  <= 1'b1;
            out_vld_q   <= 1'b1;
            state_q     <= StOut;
          end else begin
            ptr_q   <= '0;
            state_q <= StStart;
          end
        end
        StStart: state_q <= StDiv;
        StDiv: begin
          if (div_done) begin
            out_denom_q <= cells[0].value;
            out_last_q  <= (ptr_q == n_act - 1'b1);
            // a zero denomination pays nothing
            if (cells[0].value == '0) begin
              out_count_q <= '0;
            end else begin
              out_count_q <= div_quo;
              left_q      <= div_rem;
            end
            out_vld_q <= 1'b1;
            state_q   <= StOut;
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            out_vld_q <= 1'b0;
            if (out_last_q) begin
              state_q <= StIdle;
            end else begin
              ptr_q   <= ptr_q + 1'b1;
              state_q <= StStart;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, left_q, out_count_q, out_denom_q};
  assign m_axis_tlast  = out_last_q;

endmodule
